>>> rtl/tle_pkg.sv
// Shared types, key codes and the control program of the console line editor.
// Used by tle_sequencer, tle_datapath and tty_line_editor_core; depends on nothing.
package tle_pkg;

    // Key codes
    localparam logic [7:0] KEY_INTR        = 8'd3;
    localparam logic [7:0] KEY_STOP        = 8'd26;
    localparam logic [7:0] KEY_BACK        = 8'd8;
    localparam logic [7:0] KEY_NEWLINE     = 8'd10;
    localparam logic [7:0] KEY_FIRST_PRINT = 8'd32;
    localparam logic [7:0] KEY_LAST_PRINT  = 8'd126;

    // Configuration register indexes
    localparam logic REG_ECHO_ENABLE    = 1'b0;
    localparam logic REG_FOREGROUND_PID = 1'b1;

    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        KIND_ECHO  = 3'd0,
        KIND_INTR  = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_LINE  = 3'd3,
        KIND_BYTE  = 3'd4,
        KIND_EMPTY = 3'd5,
        KIND_ZERO  = 3'd6
    } kind_t;

    // Datapath actions, one per control word
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_DEC_LEN,
        ACT_CLR_IDX,
        ACT_COPY,
        ACT_COMMIT,
        ACT_STORE,
        ACT_SET_TAKE,
        ACT_RD_READY,
        ACT_FIN_READ
    } act_t;

    // Jump conditions
    typedef enum logic [4:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_IS_READ,
        C_NOT_SIG,
        C_NO_PID,
        C_IS_STOP,
        C_NOT_BACK,
        C_LINE_EMPTY,
        C_NO_ECHO,
        C_NOT_NL,
        C_COPY_MORE,
        C_NOT_PRINT,
        C_LINE_FULL,
        C_NO_DATA,
        C_ZERO_CNT,
        C_TAKE_MORE
    } cond_t;

    // How the last mark of an emitted request is formed
    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_ALWAYS,
        LAST_TAKE
    } last_t;

    typedef struct packed {
        act_t            act;
        logic            emit;
        kind_t           kind;
        last_t           last;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        logic  fetch;
        logic  go;
        act_t  act;
        logic  emit;
        kind_t kind;
        last_t last;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic is_read;
        logic is_sig;
        logic has_pid;
        logic is_stop;
        logic is_back;
        logic line_empty;
        logic echo_on;
        logic is_nl;
        logic copy_more;
        logic is_print;
        logic line_full;
        logic no_data;
        logic zero_cnt;
        logic take_more;
        logic out_free;
    } flags_t;

    // Program labels
    localparam logic [PC_W-1:0] PC_FETCH    = 5'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] PC_SIG     = 5'd2;
    localparam logic [PC_W-1:0] PC_SIG_PID = 5'd3;
    localparam logic [PC_W-1:0] PC_SIG_SEL = 5'd4;
    localparam logic [PC_W-1:0] PC_SIG_INT = 5'd5;
    localparam logic [PC_W-1:0] PC_SIG_STP = 5'd6;
    localparam logic [PC_W-1:0] PC_BK      = 5'd7;
    localparam logic [PC_W-1:0] PC_BK_CHK  = 5'd8;
    localparam logic [PC_W-1:0] PC_BK_DEC  = 5'd9;
    localparam logic [PC_W-1:0] PC_BK_ECHO = 5'd10;
    localparam logic [PC_W-1:0] PC_NL      = 5'd11;
    localparam logic [PC_W-1:0] PC_NL_CLR  = 5'd12;
    localparam logic [PC_W-1:0] PC_NL_ECHO = 5'd13;
    localparam logic [PC_W-1:0] PC_NL_COPY = 5'd14;
    localparam logic [PC_W-1:0] PC_NL_DRN  = 5'd15;
    localparam logic [PC_W-1:0] PC_NL_CMT  = 5'd16;
    localparam logic [PC_W-1:0] PC_NL_RDY  = 5'd17;
    localparam logic [PC_W-1:0] PC_PR      = 5'd18;
    localparam logic [PC_W-1:0] PC_PR_FULL = 5'd19;
    localparam logic [PC_W-1:0] PC_PR_STO  = 5'd20;
    localparam logic [PC_W-1:0] PC_PR_ECHO = 5'd21;
    localparam logic [PC_W-1:0] PC_RD      = 5'd22;
    localparam logic [PC_W-1:0] PC_RD_ZCHK = 5'd23;
    localparam logic [PC_W-1:0] PC_RD_TAKE = 5'd24;
    localparam logic [PC_W-1:0] PC_RD_MEM  = 5'd25;
    localparam logic [PC_W-1:0] PC_RD_EMIT = 5'd26;
    localparam logic [PC_W-1:0] PC_RD_FIN  = 5'd27;
    localparam logic [PC_W-1:0] PC_RD_EMPT = 5'd28;
    localparam logic [PC_W-1:0] PC_RD_ZERO = 5'd29;
    localparam logic [PC_W-1:0] PC_LAST    = PC_RD_ZERO;

    function automatic uword_t mk(input act_t a, input logic e, input kind_t k,
                                  input last_t l, input cond_t c,
                                  input logic [PC_W-1:0] t);
        uword_t w;
        w.act    = a;
        w.emit   = e;
        w.kind   = k;
        w.last   = l;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // Control store: action, then jump to target when the condition holds
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_FETCH:    w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NO_INPUT, PC_FETCH);
            PC_DISPATCH: w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_IS_READ, PC_RD);
            PC_SIG:      w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NOT_SIG, PC_BK);
            PC_SIG_PID:  w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NO_PID, PC_FETCH);
            PC_SIG_SEL:  w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_IS_STOP, PC_SIG_STP);
            PC_SIG_INT:  w = mk(ACT_NONE, 1'b1, KIND_INTR, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_SIG_STP:  w = mk(ACT_NONE, 1'b1, KIND_STOP, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_BK:       w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NOT_BACK, PC_NL);
            PC_BK_CHK:   w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_LINE_EMPTY, PC_FETCH);
            PC_BK_DEC:   w = mk(ACT_DEC_LEN, 1'b0, KIND_ECHO, LAST_NONE, C_NO_ECHO, PC_FETCH);
            PC_BK_ECHO:  w = mk(ACT_NONE, 1'b1, KIND_ECHO, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_NL:       w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NOT_NL, PC_PR);
            PC_NL_CLR:   w = mk(ACT_CLR_IDX, 1'b0, KIND_ECHO, LAST_NONE, C_NO_ECHO, PC_NL_COPY);
            PC_NL_ECHO:  w = mk(ACT_NONE, 1'b1, KIND_ECHO, LAST_NONE, C_NEVER, PC_FETCH);
            PC_NL_COPY:  w = mk(ACT_COPY, 1'b0, KIND_ECHO, LAST_NONE, C_COPY_MORE, PC_NL_COPY);
            PC_NL_DRN:   w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NEVER, PC_FETCH);
            PC_NL_CMT:   w = mk(ACT_COMMIT, 1'b0, KIND_ECHO, LAST_NONE, C_NEVER, PC_FETCH);
            PC_NL_RDY:   w = mk(ACT_NONE, 1'b1, KIND_LINE, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_PR:       w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NOT_PRINT, PC_FETCH);
            PC_PR_FULL:  w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_LINE_FULL, PC_FETCH);
            PC_PR_STO:   w = mk(ACT_STORE, 1'b0, KIND_ECHO, LAST_NONE, C_NO_ECHO, PC_FETCH);
            PC_PR_ECHO:  w = mk(ACT_NONE, 1'b1, KIND_ECHO, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_RD:       w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_NO_DATA, PC_RD_EMPT);
            PC_RD_ZCHK:  w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_ZERO_CNT, PC_RD_ZERO);
            PC_RD_TAKE:  w = mk(ACT_SET_TAKE, 1'b0, KIND_ECHO, LAST_NONE, C_NEVER, PC_FETCH);
            PC_RD_MEM:   w = mk(ACT_RD_READY, 1'b0, KIND_ECHO, LAST_NONE, C_NEVER, PC_FETCH);
            PC_RD_EMIT:  w = mk(ACT_NONE, 1'b1, KIND_BYTE, LAST_TAKE, C_TAKE_MORE, PC_RD_MEM);
            PC_RD_FIN:   w = mk(ACT_FIN_READ, 1'b0, KIND_ECHO, LAST_NONE, C_ALWAYS, PC_FETCH);
            PC_RD_EMPT:  w = mk(ACT_NONE, 1'b1, KIND_EMPTY, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            PC_RD_ZERO:  w = mk(ACT_NONE, 1'b1, KIND_ZERO, LAST_ALWAYS, C_ALWAYS, PC_FETCH);
            default:     w = mk(ACT_NONE, 1'b0, KIND_ECHO, LAST_NONE, C_ALWAYS, PC_FETCH);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/tty_line_editor_core.sv
// Top level of the console line editor: configuration registers and the
// sequencer/datapath pair. Depends on tle_pkg, tle_sequencer and tle_datapath.
//
//  Channel   Direction  Handshake             Payload
//  s_*       in         s_valid / s_ready     s_opcode, s_key_byte, s_read_count
//  m_*       out        m_valid / m_ready     m_kind, m_data_byte, m_target_pid, m_last
//  cfg_*     in         cfg_wr_en (no wait)   cfg_index, cfg_wdata
//
// One request at a time; s_ready is high only in the fetch step of the control program.
// A newline echoes first (not with echo off), then copies the line one byte per cycle
// between the two stores; a read fetches each returned byte from the read store before
// issuing it, or issues a single empty or zero result when it returns no data.
// Synchronous active-low reset; both stores are left as they are, with no clearing pass.
// A stalled m_ready holds the sequencer on its issuing step; the output register lets the
// next step proceed while one result waits.
module tty_line_editor_core #(
    parameter int LINE_BYTES = 128,
    parameter int MAX_READ   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_key_byte,
    input  logic [6:0]  s_read_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_target_pid,
    output logic        m_last
);

    logic            echo_enable_reg;
    logic [15:0]     fg_pid_reg;
    tle_pkg::ctrl_t  ctrl;
    tle_pkg::flags_t flags;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg <= 1'b1;
            fg_pid_reg      <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tle_pkg::REG_ECHO_ENABLE:    echo_enable_reg <= cfg_wdata[0];
                tle_pkg::REG_FOREGROUND_PID: fg_pid_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = ctrl.fetch;

    tle_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tle_datapath #(
        .LINE_BYTES (LINE_BYTES),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .flags        (flags),
        .echo_on      (echo_enable_reg),
        .fg_pid       (fg_pid_reg),
        .s_valid      (s_valid),
        .s_opcode     (s_opcode),
        .s_key_byte   (s_key_byte),
        .s_read_count (s_read_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_target_pid (m_target_pid),
        .m_last       (m_last)
    );

endmodule

>>> rtl/tle_sequencer.sv
// Step counter, control store fetch and jump logic of the line editor.
// Depends on tle_pkg for the control word, flag and control types.
module tle_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  tle_pkg::flags_t flags,
    output tle_pkg::ctrl_t  ctrl
);

    logic [tle_pkg::PC_W-1:0] pc_reg;
    logic [tle_pkg::PC_W-1:0] pc_next;
    tle_pkg::uword_t          uword;
    logic                     cond_hit;
    logic                     go;

    // Fetch the control word of the current step
    assign uword = tle_pkg::ucode_rom(pc_reg);

    // A step that issues a request waits for room in the output register
    assign go = !uword.emit || flags.out_free;

    // Evaluate the jump condition
    always_comb begin
        case (uword.cond)
            tle_pkg::C_NEVER:      cond_hit = 1'b0;
            tle_pkg::C_ALWAYS:     cond_hit = 1'b1;
            tle_pkg::C_NO_INPUT:   cond_hit = !flags.in_valid;
            tle_pkg::C_IS_READ:    cond_hit = flags.is_read;
            tle_pkg::C_NOT_SIG:    cond_hit = !flags.is_sig;
            tle_pkg::C_NO_PID:     cond_hit = !flags.has_pid;
            tle_pkg::C_IS_STOP:    cond_hit = flags.is_stop;
            tle_pkg::C_NOT_BACK:   cond_hit = !flags.is_back;
            tle_pkg::C_LINE_EMPTY: cond_hit = flags.line_empty;
            tle_pkg::C_NO_ECHO:    cond_hit = !flags.echo_on;
            tle_pkg::C_NOT_NL:     cond_hit = !flags.is_nl;
            tle_pkg::C_COPY_MORE:  cond_hit = flags.copy_more;
            tle_pkg::C_NOT_PRINT:  cond_hit = !flags.is_print;
            tle_pkg::C_LINE_FULL:  cond_hit = flags.line_full;
            tle_pkg::C_NO_DATA:    cond_hit = flags.no_data;
            tle_pkg::C_ZERO_CNT:   cond_hit = flags.zero_cnt;
            tle_pkg::C_TAKE_MORE:  cond_hit = flags.take_more;
            default:               cond_hit = 1'b0;
        endcase
    end

    // Advance or jump; hold while stalled
    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            if (cond_hit) begin
                pc_next = uword.target;
            end else begin
                pc_next = tle_pkg::PC_W'(pc_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= tle_pkg::PC_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Drive the datapath
    always_comb begin
        ctrl.fetch = (pc_reg == tle_pkg::PC_FETCH);
        ctrl.go    = go;
        ctrl.act   = uword.act;
        ctrl.emit  = uword.emit;
        ctrl.kind  = uword.kind;
        ctrl.last  = uword.last;
    end

    // Step counter stays inside the program
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= tle_pkg::PC_LAST)
        else $error("step counter left the program");

    // An accepted request is dispatched on the next step
    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.fetch && flags.in_valid) |=> (pc_reg == tle_pkg::PC_DISPATCH))
        else $error("accepted request not dispatched");

    // The fetch step never issues a result
    a_fetch_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fetch |-> !ctrl.emit)
        else $error("result issued while fetching");

endmodule

>>> rtl/tle_datapath.sv
// Line and read stores, length and position counters, input latch and output register.
// Depends on tle_pkg for control, flag, kind and key code definitions.
module tle_datapath #(
    parameter int LINE_BYTES = 128,
    parameter int MAX_READ   = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  tle_pkg::ctrl_t  ctrl,
    output tle_pkg::flags_t flags,
    input  logic            echo_on,
    input  logic [15:0]     fg_pid,
    input  logic            s_valid,
    input  logic            s_opcode,
    input  logic [7:0]      s_key_byte,
    input  logic [6:0]      s_read_count,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_data_byte,
    output logic [15:0]     m_target_pid,
    output logic            m_last
);

    localparam int AW    = $clog2(LINE_BYTES);
    localparam int LEN_W = AW + 1;
    localparam int CMP_W = (LEN_W > 7) ? LEN_W : 7;

    // Stores
    logic [7:0] line_mem  [LINE_BYTES];
    logic [7:0] ready_mem [LINE_BYTES];

    // Latched request
    logic       op_reg;
    logic [7:0] key_reg;
    logic [6:0] cnt_reg;

    // Counters
    logic [AW-1:0]    line_len_reg,  line_len_next;
    logic [LEN_W-1:0] ready_len_reg, ready_len_next;
    logic [LEN_W-1:0] ready_pos_reg, ready_pos_next;
    logic [AW-1:0]    idx_reg,       idx_next;
    logic [6:0]       take_reg,      take_next;

    // Copy pipeline
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic [7:0]    line_rd_q;
    logic [7:0]    ready_rd_q;

    // Output register
    logic        m_valid_reg;
    logic [2:0]  m_kind_reg;
    logic [7:0]  m_data_reg;
    logic [15:0] m_pid_reg;
    logic        m_last_reg;

    logic             accept;
    logic             out_free;
    logic             load_out;
    logic             copy_rd;
    logic [LEN_W-1:0] avail;
    logic [CMP_W-1:0] avail_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [7:0]       out_data;
    logic [15:0]      out_pid;
    logic             out_last;

    assign accept   = ctrl.fetch && s_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = ctrl.go && ctrl.emit;
    assign copy_rd  = ctrl.go && (ctrl.act == tle_pkg::ACT_COPY)
                      && (idx_reg != line_len_reg);

    assign avail     = ready_len_reg - ready_pos_reg;
    assign avail_ext = CMP_W'(avail);
    assign cnt_ext   = CMP_W'(cnt_reg);

    // Flags for the sequencer
    always_comb begin
        flags.in_valid   = s_valid;
        flags.is_read    = op_reg;
        flags.is_sig     = (key_reg == tle_pkg::KEY_INTR) || (key_reg == tle_pkg::KEY_STOP);
        flags.has_pid    = (fg_pid != 16'd0);
        flags.is_stop    = (key_reg == tle_pkg::KEY_STOP);
        flags.is_back    = (key_reg == tle_pkg::KEY_BACK);
        flags.line_empty = (line_len_reg == '0);
        flags.echo_on    = echo_on;
        flags.is_nl      = (key_reg == tle_pkg::KEY_NEWLINE);
        flags.copy_more  = ((LEN_W'(idx_reg) + 1'b1) < LEN_W'(line_len_reg));
        flags.is_print   = key_reg inside {[tle_pkg::KEY_FIRST_PRINT:tle_pkg::KEY_LAST_PRINT]};
        flags.line_full  = (line_len_reg == AW'(LINE_BYTES - 1));
        flags.no_data    = (ready_len_reg == '0) || (ready_pos_reg >= ready_len_reg);
        flags.zero_cnt   = (cnt_reg == 7'd0);
        flags.take_more  = (take_reg != 7'd0);
        flags.out_free   = out_free;
    end

    // Latch the request; clamp the read count
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_opcode;
            key_reg <= s_key_byte;
            cnt_reg <= (s_read_count > 7'(MAX_READ)) ? 7'(MAX_READ) : s_read_count;
        end
    end

    // Counter updates
    always_comb begin
        line_len_next  = line_len_reg;
        ready_len_next = ready_len_reg;
        ready_pos_next = ready_pos_reg;
        idx_next       = idx_reg;
        take_next      = take_reg;
        if (ctrl.go) begin
            case (ctrl.act)
                tle_pkg::ACT_DEC_LEN: line_len_next = line_len_reg - 1'b1;
                tle_pkg::ACT_CLR_IDX: idx_next = '0;
                tle_pkg::ACT_COPY: begin
                    if (copy_rd) begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                tle_pkg::ACT_COMMIT: begin
                    ready_len_next = LEN_W'(line_len_reg) + 1'b1;
                    ready_pos_next = '0;
                    line_len_next  = '0;
                end
                tle_pkg::ACT_STORE: line_len_next = line_len_reg + 1'b1;
                tle_pkg::ACT_SET_TAKE: begin
                    take_next = 7'((cnt_ext < avail_ext) ? cnt_ext : avail_ext);
                end
                tle_pkg::ACT_RD_READY: begin
                    ready_pos_next = ready_pos_reg + 1'b1;
                    take_next      = take_reg - 1'b1;
                end
                tle_pkg::ACT_FIN_READ: begin
                    if (ready_pos_reg >= ready_len_reg) begin
                        ready_pos_next = '0;
                        ready_len_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_len_reg  <= '0;
            ready_len_reg <= '0;
            ready_pos_reg <= '0;
            idx_reg       <= '0;
            take_reg      <= '0;
            wr_pend_reg   <= 1'b0;
        end else begin
            line_len_reg  <= line_len_next;
            ready_len_reg <= ready_len_next;
            ready_pos_reg <= ready_pos_next;
            idx_reg       <= idx_next;
            take_reg      <= take_next;
            wr_pend_reg   <= copy_rd;
        end
    end

    // Line store: write typed bytes, read during copy
    always_ff @(posedge aclk) begin
        if (ctrl.go && (ctrl.act == tle_pkg::ACT_STORE)) begin
            line_mem[line_len_reg] <= key_reg;
        end
        if (copy_rd) begin
            line_rd_q   <= line_mem[idx_reg];
            wr_addr_reg <= idx_reg;
        end
    end

    // Read store: write copied bytes and the closing newline, read on requests
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            ready_mem[wr_addr_reg] <= line_rd_q;
        end else if (ctrl.go && (ctrl.act == tle_pkg::ACT_COMMIT)) begin
            ready_mem[line_len_reg] <= tle_pkg::KEY_NEWLINE;
        end
        if (ctrl.go && (ctrl.act == tle_pkg::ACT_RD_READY)) begin
            ready_rd_q <= ready_mem[ready_pos_reg[AW-1:0]];
        end
    end

    // Select the result payload
    always_comb begin
        out_data = 8'd0;
        out_pid  = 16'd0;
        case (ctrl.kind)
            tle_pkg::KIND_ECHO: out_data = key_reg;
            tle_pkg::KIND_BYTE: out_data = ready_rd_q;
            tle_pkg::KIND_INTR: out_pid  = fg_pid;
            tle_pkg::KIND_STOP: out_pid  = fg_pid;
            default: ;
        endcase
        case (ctrl.last)
            tle_pkg::LAST_ALWAYS: out_last = 1'b1;
            tle_pkg::LAST_TAKE:   out_last = (take_reg == 7'd0);
            default:              out_last = 1'b0;
        endcase
    end

    // Output register: load a new request, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_kind_reg <= ctrl.kind;
            m_data_reg <= out_data;
            m_pid_reg  <= out_pid;
            m_last_reg <= out_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_data_byte  = m_data_reg;
    assign m_target_pid = m_pid_reg;
    assign m_last       = m_last_reg;

    // Line length never reaches the store size
    a_line_len: assert property (@(posedge aclk) disable iff (!aresetn)
        LEN_W'(line_len_reg) < LEN_W'(LINE_BYTES))
        else $error("line length overflow");

    // Read position never passes the read length
    a_ready_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_pos_reg <= ready_len_reg)
        else $error("read position past end of data");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

endmodule

>>> sim/tty_line_editor_core_tb.sv
// Testbench for tty_line_editor_core: a directed table, then random key and read requests.
// Every result is checked against an in-bench model of the line editor, or against the outcome typed into a pinned row.
// Depends on tle_pkg and the RTL of tty_line_editor_core.
module tty_line_editor_core_tb;

    localparam int LINE_BYTES    = 128;
    localparam int MAX_READ      = 64;
    localparam int RANDOM_ITEMS  = 255;
    localparam int STEADY_FROM   = 215;
    localparam int CFG_SPACING   = 60;
    localparam int SETTLE_CYCLES = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_TIME    = 6000000;
    localparam int N_ROWS        = 30;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        tle_pkg::kind_t kind;
        logic [7:0]     data;
        logic [15:0]    pid;
        logic           last;
    } editor_result_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_SETTING
    } row_kind_t;

    typedef struct packed {
        row_kind_t      what;
        logic           op;
        logic [7:0]     key;
        logic [6:0]     cnt;
        logic           cfg_idx;
        logic [15:0]    cfg_val;
        logic           pinned;
        logic           has_res;
        editor_result_t res;
    } stim_row_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic        cfg_index    = 1'b0;
    logic [15:0] cfg_wdata    = 16'd0;
    logic        s_valid      = 1'b0;
    logic        s_opcode     = 1'b0;
    logic [7:0]  s_key_byte   = 8'd0;
    logic [6:0]  s_read_count = 7'd0;
    logic        m_ready      = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [15:0] m_target_pid;
    logic        m_last;

    // Model state and settings
    logic [7:0]  line_buf  [LINE_BYTES];
    logic [7:0]  ready_buf [LINE_BYTES];
    int          line_len  = 0;
    int          ready_len = 0;
    int          ready_pos = 0;
    logic        echo_on   = 1'b1;
    logic [15:0] fg_pid    = 16'd0;

    editor_result_t step_results[$];
    editor_result_t expected_results[$];
    int             mismatches    = 0;
    int             items_sent    = 0;
    bit             steady_tail   = 1'b0;
    bit             hold_request  = 1'b0;

    stim_row_t directed_rows [N_ROWS];

    tty_line_editor_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key_byte   (s_key_byte),
        .s_read_count (s_read_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_target_pid (m_target_pid),
        .m_last       (m_last)
    );

    always #2 aclk = ~aclk;

    // Table rows: a request checked by the model, one with its outcome typed in, or a register setting
    function automatic stim_row_t req(logic op, logic [7:0] key, logic [6:0] cnt);
        stim_row_t r;
        r = '0;
        r.what = ROW_REQUEST;
        r.op   = op;
        r.key  = key;
        r.cnt  = cnt;
        return r;
    endfunction

    function automatic stim_row_t pinned(logic op, logic [7:0] key, logic [6:0] cnt,
                                         logic has_res, tle_pkg::kind_t kind,
                                         logic [7:0] data, logic [15:0] pid);
        stim_row_t r;
        r = req(op, key, cnt);
        r.pinned   = 1'b1;
        r.has_res  = has_res;
        r.res.kind = kind;
        r.res.data = data;
        r.res.pid  = pid;
        r.res.last = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t setting(logic idx, logic [15:0] val);
        stim_row_t r;
        r = '0;
        r.what    = ROW_SETTING;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic void add_result(tle_pkg::kind_t kind, logic [7:0] data,
                                       logic [15:0] pid);
        editor_result_t r;
        r.kind = kind;
        r.data = data;
        r.pid  = pid;
        r.last = 1'b0;
        step_results.push_back(r);
    endfunction

    // Advance the editor model by one request; leave its results in step_results
    function automatic void model_request(logic op, logic [7:0] key, logic [6:0] cnt);
        int i;
        int want;
        int take;
        editor_result_t r;
        step_results.delete();
        if (op == OP_KEY) begin
            if (key == tle_pkg::KEY_INTR || key == tle_pkg::KEY_STOP) begin
                if (fg_pid != 16'd0) begin
                    if (key == tle_pkg::KEY_INTR)
                        add_result(tle_pkg::KIND_INTR, 8'd0, fg_pid);
                    else
                        add_result(tle_pkg::KIND_STOP, 8'd0, fg_pid);
                end
            end else if (key == tle_pkg::KEY_BACK) begin
                if (line_len > 0) begin
                    line_len--;
                    if (echo_on)
                        add_result(tle_pkg::KIND_ECHO, tle_pkg::KEY_BACK, 16'd0);
                end
            end else if (key == tle_pkg::KEY_NEWLINE) begin
                if (echo_on)
                    add_result(tle_pkg::KIND_ECHO, tle_pkg::KEY_NEWLINE, 16'd0);
                for (i = 0; i < line_len; i++)
                    ready_buf[i] = line_buf[i];
                if (line_len < LINE_BYTES)
                    ready_buf[line_len] = tle_pkg::KEY_NEWLINE;
                ready_len = line_len + 1;
                ready_pos = 0;
                line_len  = 0;
                add_result(tle_pkg::KIND_LINE, 8'd0, 16'd0);
            end else if (key >= tle_pkg::KEY_FIRST_PRINT && key <= tle_pkg::KEY_LAST_PRINT) begin
                // drop the byte once the line is full
                if (line_len < LINE_BYTES - 1) begin
                    line_buf[line_len] = key;
                    line_len++;
                    if (echo_on)
                        add_result(tle_pkg::KIND_ECHO, key, 16'd0);
                end
            end
        end else begin
            want = (cnt > MAX_READ) ? MAX_READ : int'(cnt);
            if (ready_len == 0 || ready_pos >= ready_len) begin
                add_result(tle_pkg::KIND_EMPTY, 8'd0, 16'd0);
            end else if (want == 0) begin
                add_result(tle_pkg::KIND_ZERO, 8'd0, 16'd0);
            end else begin
                take = (want < ready_len - ready_pos) ? want : ready_len - ready_pos;
                for (i = 0; i < take; i++)
                    add_result(tle_pkg::KIND_BYTE, ready_buf[ready_pos + i], 16'd0);
                ready_pos += take;
                if (ready_pos >= ready_len) begin
                    ready_pos = 0;
                    ready_len = 0;
                end
            end
        end
        if (step_results.size() > 0) begin
            r = step_results[step_results.size() - 1];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
    endfunction

    // Offer one request, with an optional gap first; return at the accepting edge
    task automatic send_request(logic op, logic [7:0] key, logic [6:0] cnt);
        @(negedge aclk);
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_key_byte   <= key;
        s_read_count <= cnt;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic issue(logic op, logic [7:0] key, logic [6:0] cnt);
        send_request(op, key, cnt);
        model_request(op, key, cnt);
        foreach (step_results[k])
            expected_results.push_back(step_results[k]);
        items_sent++;
    endtask

    // Write a register once the block has drained and settled
    task automatic write_register(logic idx, logic [15:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tle_pkg::REG_ECHO_ENABLE)
            echo_on = val[0];
        else
            fg_pid = val;
    endtask

    function automatic logic [6:0] read_size();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 7'd0;
        else if (pick == 1)
            return 7'($urandom_range(64, 127));
        else
            return 7'($urandom_range(1, 12));
    endfunction

    initial begin : stimulus
        stim_row_t row;
        int        i;
        int        len;
        int        pick;
        int        n_directed;
        int        next_cfg;
        bit        long_done;

        directed_rows = '{
            pinned(OP_READ, 8'd0, 7'd5, 1'b1, tle_pkg::KIND_EMPTY, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_INTR, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_STOP, 7'd127, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_BACK, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, 8'h00, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, 8'hFF, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, 8'h7F, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, 8'h1F, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_FIRST_PRINT, 7'd0, 1'b1, tle_pkg::KIND_ECHO,
                   tle_pkg::KEY_FIRST_PRINT, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_LAST_PRINT, 7'd0, 1'b1, tle_pkg::KIND_ECHO,
                   tle_pkg::KEY_LAST_PRINT, 16'd0),
            req(OP_KEY, 8'h41, 7'd0),
            pinned(OP_KEY, tle_pkg::KEY_BACK, 7'd0, 1'b1, tle_pkg::KIND_ECHO,
                   tle_pkg::KEY_BACK, 16'd0),
            req(OP_KEY, tle_pkg::KEY_NEWLINE, 7'd0),
            pinned(OP_READ, 8'd0, 7'd0, 1'b1, tle_pkg::KIND_ZERO, 8'd0, 16'd0),
            req(OP_READ, 8'd0, 7'd1),
            req(OP_READ, 8'd0, 7'd127),
            pinned(OP_READ, 8'd0, 7'd64, 1'b1, tle_pkg::KIND_EMPTY, 8'd0, 16'd0),
            req(OP_KEY, tle_pkg::KEY_NEWLINE, 7'd0),
            req(OP_READ, 8'hFF, 7'd64),
            setting(tle_pkg::REG_FOREGROUND_PID, 16'hFFFF),
            pinned(OP_KEY, tle_pkg::KEY_INTR, 7'd0, 1'b1, tle_pkg::KIND_INTR, 8'd0, 16'hFFFF),
            pinned(OP_KEY, tle_pkg::KEY_STOP, 7'd0, 1'b1, tle_pkg::KIND_STOP, 8'd0, 16'hFFFF),
            setting(tle_pkg::REG_ECHO_ENABLE, 16'd0),
            pinned(OP_KEY, 8'h78, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_BACK, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, 8'h71, 7'd0, 1'b0, tle_pkg::KIND_ECHO, 8'd0, 16'd0),
            pinned(OP_KEY, tle_pkg::KEY_NEWLINE, 7'd0, 1'b1, tle_pkg::KIND_LINE, 8'd0, 16'd0),
            req(OP_READ, 8'd0, 7'd64),
            setting(tle_pkg::REG_ECHO_ENABLE, 16'd1),
            setting(tle_pkg::REG_FOREGROUND_PID, 16'd0)
        };

        // Hold reset, then release it on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.what == ROW_SETTING) begin
                write_register(row.cfg_idx, row.cfg_val);
            end else if (!row.pinned) begin
                issue(row.op, row.key, row.cnt);
            end else begin
                send_request(row.op, row.key, row.cnt);
                model_request(row.op, row.key, row.cnt);
                if (row.has_res)
                    expected_results.push_back(row.res);
                items_sent++;
            end
        end

        // Random part: mostly typed lines followed by reads, some signals and noise, register writes, one long line
        n_directed   = items_sent;
        next_cfg     = n_directed + CFG_SPACING;
        long_done    = 1'b0;
        hold_request = 1'b1;
        while (items_sent < n_directed + RANDOM_ITEMS) begin
            if (items_sent >= n_directed + STEADY_FROM)
                steady_tail = 1'b1;
            if (!long_done && items_sent > n_directed + 80) begin
                // fill the line past its limit, then drain the full read store
                for (i = 0; i < LINE_BYTES + 2; i++)
                    issue(OP_KEY, 8'($urandom_range(32, 126)), 7'($urandom_range(0, 127)));
                issue(OP_KEY, tle_pkg::KEY_NEWLINE, 7'($urandom_range(0, 127)));
                issue(OP_READ, 8'($urandom_range(0, 255)), 7'd64);
                issue(OP_READ, 8'($urandom_range(0, 255)), 7'd127);
                issue(OP_READ, 8'($urandom_range(0, 255)), 7'd5);
                long_done = 1'b1;
            end else if (items_sent >= next_cfg && !steady_tail) begin
                write_register(tle_pkg::REG_ECHO_ENABLE, 16'($urandom_range(0, 1)));
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_register(tle_pkg::REG_FOREGROUND_PID, 16'd0);
                else if (pick == 1)
                    write_register(tle_pkg::REG_FOREGROUND_PID, 16'hFFFF);
                else
                    write_register(tle_pkg::REG_FOREGROUND_PID,
                                   16'($urandom_range(1, 65534)));
                next_cfg += CFG_SPACING;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 10);
                    for (i = 0; i < len; i++) begin
                        if ($urandom_range(0, 7) == 0)
                            issue(OP_KEY, tle_pkg::KEY_BACK, 7'($urandom_range(0, 127)));
                        else
                            issue(OP_KEY, 8'($urandom_range(32, 126)),
                                  7'($urandom_range(0, 127)));
                    end
                    if ($urandom_range(0, 1) == 0)
                        issue(OP_READ, 8'($urandom_range(0, 255)), read_size());
                    if ($urandom_range(0, 7) != 0)
                        issue(OP_KEY, tle_pkg::KEY_NEWLINE, 7'($urandom_range(0, 127)));
                    repeat ($urandom_range(0, 3))
                        issue(OP_READ, 8'($urandom_range(0, 255)), read_size());
                end else if (pick < 7) begin
                    issue(OP_KEY,
                          ($urandom_range(0, 1) == 0) ? tle_pkg::KEY_INTR : tle_pkg::KEY_STOP,
                          7'($urandom_range(0, 127)));
                end else if (pick < 9) begin
                    issue(OP_KEY, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                end else begin
                    issue(OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
                end
            end
        end

        // Drain, settle, report
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random stall bursts, calm stretches, one long hold-off
    initial begin : result_sink
        int calm_left;
        calm_left = 0;
        forever begin
            @(negedge aclk);
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 39) == 0)
                calm_left = $urandom_range(20, 200);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!steady_tail && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        editor_result_t got;
        editor_result_t want;
        bit             stray;
        if (aresetn && m_valid && m_ready) begin
            got.kind = tle_pkg::kind_t'(m_kind);
            got.data = m_data_byte;
            got.pid  = m_target_pid;
            got.last = m_last;
            stray = (expected_results.size() == 0);
            want  = stray ? editor_result_t'('0) : expected_results.pop_front();
            if (stray || got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t%s: expected kind %0d data %02h pid %04h last %0b,",
                             $time, stray ? " (nothing expected)" : "",
                             want.kind, want.data, want.pid, want.last,
                             " got kind %0d data %02h pid %04h last %0b",
                             got.kind, got.data, got.pid, got.last);
            end
        end
    end

    // Stop a hung run
    initial begin
        #(LIMIT_TIME);
        $display("tb: failure");
        $finish;
    end

endmodule
